### src/lavm_pkg.sv
// Shared constants, types and latency function for the look-at view matrix block.
package lavm_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int AXIS_W        = 18;
   localparam int WORD_W        = 32;
   localparam int NORM_W        = 30;
   localparam int SQ_STEPS      = 31;
   localparam int SH_W          = 6;

   function automatic int unit_lat(input int frac);
      return frac + 39;
   endfunction

   typedef struct packed {
      logic signed [AXIS_W-1:0] right_x;
      logic signed [AXIS_W-1:0] right_y;
      logic signed [AXIS_W-1:0] right_z;
      logic signed [AXIS_W-1:0] camup_x;
      logic signed [AXIS_W-1:0] camup_y;
      logic signed [AXIS_W-1:0] camup_z;
      logic signed [AXIS_W-1:0] back_x;
      logic signed [AXIS_W-1:0] back_y;
      logic signed [AXIS_W-1:0] back_z;
      logic signed [WORD_W-1:0] shift_x;
      logic signed [WORD_W-1:0] shift_y;
      logic signed [WORD_W-1:0] shift_z;
   } rsp_type;

endpackage

### src/lavm_unit.sv
// Pipelined vector normalizer: block shift, sum of squares, square root, divide.
module lavm_unit import lavm_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int IN_W      = 33
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [IN_W-1:0]      in_x,
   input  logic signed [IN_W-1:0]      in_y,
   input  logic signed [IN_W-1:0]      in_z,
   output logic signed [FRAC_BITS+1:0] out_x,
   output logic signed [FRAC_BITS+1:0] out_y,
   output logic signed [FRAC_BITS+1:0] out_z
);

   localparam int AW     = FRAC_BITS + 2;
   localparam int XW     = IN_W + NORM_W;
   localparam int SQ_W   = 2 * NORM_W;
   localparam int SUM_W  = 2 * NORM_W + 2;
   localparam int REM_W  = SQ_STEPS + 2;
   localparam int RW     = SQ_STEPS;
   localparam int NW     = NORM_W + FRAC_BITS + 1;
   localparam int QW     = FRAC_BITS + 1;
   localparam int DSTEPS = FRAC_BITS + 1;

   logic signed [IN_W-1:0] vin [3];
   assign vin[0] = in_x;
   assign vin[1] = in_y;
   assign vin[2] = in_z;

   // stage 1: magnitudes and largest magnitude
   logic [2:0][IN_W-1:0] mag1_in, mag1_ff;
   logic [2:0]           neg1_in, neg1_ff;
   logic [IN_W-1:0]      m1_in, m1_ff;

   always_comb begin
      m1_in = '0;
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = vin[i][IN_W-1];
         mag1_in[i] = neg1_in[i] ? IN_W'(-vin[i]) : IN_W'(vin[i]);
         if (mag1_in[i] > m1_in) m1_in = mag1_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff <= mag1_in;
         neg1_ff <= neg1_in;
         m1_ff   <= m1_in;
      end
   end

   // stage 2: shift amounts that bring the largest magnitude to [2^29, 2^30)
   logic [SH_W-1:0]      pos2, rs2_in, ls2_in, rs2_ff, ls2_ff;
   logic [2:0][IN_W-1:0] mag2_ff;
   logic [2:0]           neg2_ff;
   logic                 zero2_ff;

   always_comb begin
      pos2 = '0;
      for (int i = 0; i < IN_W; i++) begin
         if (m1_ff[i]) pos2 = SH_W'(i);
      end
      if (pos2 >= SH_W'(NORM_W)) begin
         rs2_in = pos2 - SH_W'(NORM_W - 1);
         ls2_in = '0;
      end else begin
         rs2_in = '0;
         ls2_in = SH_W'(NORM_W - 1) - pos2;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rs2_ff   <= rs2_in;
         ls2_ff   <= ls2_in;
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
         zero2_ff <= (m1_ff == '0);
      end
   end

   // stage 3: apply the shift
   logic [2:0][NORM_W-1:0] sh3_in, sh3_ff;
   logic [2:0]             neg3_ff;
   logic                   zero3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++)
         sh3_in[i] = NORM_W'((XW'(mag2_ff[i]) >> rs2_ff) << ls2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sh3_ff   <= sh3_in;
         neg3_ff  <= neg2_ff;
         zero3_ff <= zero2_ff;
      end
   end

   // stage 4: squares
   logic [2:0][SQ_W-1:0]   sq4_in, sq4_ff;
   logic [2:0][NORM_W-1:0] sh4_ff;
   logic [2:0]             neg4_ff;
   logic                   zero4_ff;

   always_comb begin
      for (int i = 0; i < 3; i++)
         sq4_in[i] = SQ_W'(sh3_ff[i]) * SQ_W'(sh3_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq4_ff   <= sq4_in;
         sh4_ff   <= sh3_ff;
         neg4_ff  <= neg3_ff;
         zero4_ff <= zero3_ff;
      end
   end

   // stage 5: sum of squares
   logic [SUM_W-1:0]       sum5_ff;
   logic [2:0][NORM_W-1:0] sh5_ff;
   logic [2:0]             neg5_ff;
   logic                   zero5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sum5_ff  <= SUM_W'(sq4_ff[0]) + SUM_W'(sq4_ff[1]) + SUM_W'(sq4_ff[2]);
         sh5_ff   <= sh4_ff;
         neg5_ff  <= neg4_ff;
         zero5_ff <= zero4_ff;
      end
   end

   // floor square root, one result bit per stage
   logic [REM_W-1:0]       rem_ff  [SQ_STEPS];
   logic [RW-1:0]          root_ff [SQ_STEPS];
   logic [SUM_W-1:0]       val_ff  [SQ_STEPS];
   logic [2:0][NORM_W-1:0] shs_ff  [SQ_STEPS];
   logic [2:0]             negs_ff [SQ_STEPS];
   logic                   zs_ff   [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      logic [REM_W-1:0]       rem_prev;
      logic [RW-1:0]          root_prev;
      logic [SUM_W-1:0]       val_prev;
      logic [2:0][NORM_W-1:0] sh_prev;
      logic [2:0]             neg_prev;
      logic                   zero_prev;
      logic [REM_W+1:0]       cat, trial;
      logic                   ge;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign val_prev  = sum5_ff;
         assign sh_prev   = sh5_ff;
         assign neg_prev  = neg5_ff;
         assign zero_prev = zero5_ff;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign val_prev  = val_ff[k-1];
         assign sh_prev   = shs_ff[k-1];
         assign neg_prev  = negs_ff[k-1];
         assign zero_prev = zs_ff[k-1];
      end

      always_comb begin
         cat   = {rem_prev, val_prev[SUM_W-1-2*k -: 2]};
         trial = (REM_W+2)'({root_prev, 2'b01});
         ge    = (cat >= trial);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? REM_W'(cat - trial) : REM_W'(cat);
            root_ff[k] <= {root_prev[RW-2:0], ge};
            val_ff[k]  <= val_prev;
            shs_ff[k]  <= sh_prev;
            negs_ff[k] <= neg_prev;
            zs_ff[k]   <= zero_prev;
         end
      end
   end

   // numerator with half the length added for rounding
   logic [2:0][NW-1:0] num6_in, num6_ff;
   logic [RW-1:0]      len6_ff;
   logic [2:0]         neg6_ff;
   logic               zero6_ff;

   always_comb begin
      for (int i = 0; i < 3; i++)
         num6_in[i] = (NW'(shs_ff[SQ_STEPS-1][i]) << FRAC_BITS)
                    + NW'(root_ff[SQ_STEPS-1] >> 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num6_ff  <= num6_in;
         len6_ff  <= root_ff[SQ_STEPS-1];
         neg6_ff  <= negs_ff[SQ_STEPS-1];
         zero6_ff <= zs_ff[SQ_STEPS-1];
      end
   end

   // restoring division, one quotient bit per stage, three lanes
   logic [2:0][RW-1:0] dr_ff   [DSTEPS];
   logic [2:0][QW-1:0] dq_ff   [DSTEPS];
   logic [2:0][NW-1:0] dnum_ff [DSTEPS];
   logic [RW-1:0]      dlen_ff [DSTEPS];
   logic [2:0]         dneg_ff [DSTEPS];
   logic               dz_ff   [DSTEPS];

   for (genvar d = 0; d < DSTEPS; d++) begin : g_div
      logic [2:0][RW-1:0] r_prev, r_next;
      logic [2:0][QW-1:0] q_prev, q_next;
      logic [2:0][NW-1:0] num_prev;
      logic [RW-1:0]      len_prev;
      logic [2:0]         neg_prev;
      logic               zero_prev;
      logic [RW:0]        dcat;

      if (d == 0) begin : g_first
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign r_prev[i] = RW'(num6_ff[i][NW-1:FRAC_BITS+1]);
         end
         assign q_prev    = '0;
         assign num_prev  = num6_ff;
         assign len_prev  = len6_ff;
         assign neg_prev  = neg6_ff;
         assign zero_prev = zero6_ff;
      end else begin : g_next
         assign r_prev    = dr_ff[d-1];
         assign q_prev    = dq_ff[d-1];
         assign num_prev  = dnum_ff[d-1];
         assign len_prev  = dlen_ff[d-1];
         assign neg_prev  = dneg_ff[d-1];
         assign zero_prev = dz_ff[d-1];
      end

      always_comb begin
         dcat = '0;
         for (int i = 0; i < 3; i++) begin
            dcat = {r_prev[i], num_prev[i][FRAC_BITS-d]};
            if (dcat >= (RW+1)'(len_prev)) begin
               r_next[i] = RW'(dcat - (RW+1)'(len_prev));
               q_next[i] = {q_prev[i][QW-2:0], 1'b1};
            end else begin
               r_next[i] = RW'(dcat);
               q_next[i] = {q_prev[i][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dr_ff[d]   <= r_next;
            dq_ff[d]   <= q_next;
            dnum_ff[d] <= num_prev;
            dlen_ff[d] <= len_prev;
            dneg_ff[d] <= neg_prev;
            dz_ff[d]   <= zero_prev;
         end
      end
   end

   // restore signs; a zero-length vector gives zero
   logic signed [AW-1:0] res_in [3];
   logic signed [AW-1:0] res_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dz_ff[DSTEPS-1])
            res_in[i] = '0;
         else if (dneg_ff[DSTEPS-1][i])
            res_in[i] = -(AW'(dq_ff[DSTEPS-1][i]));
         else
            res_in[i] = AW'(dq_ff[DSTEPS-1][i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign out_x = res_ff[0];
   assign out_y = res_ff[1];
   assign out_z = res_ff[2];

endmodule

### src/look_at_view_matrix_top.sv
// Throughput: one beat per cycle while the output queue is not full; each
// normalizer is a FRAC_BITS+39 stage pipeline (31 square-root stages, FRAC_BITS+1
// divide stages) and two run in series. A two-entry output queue takes results while
// the consumer stalls; the pipeline holds only when that queue is full.
// Reset: synchronous, active high; clears valid bits and the queue, no payload reset.
module look_at_view_matrix_top import lavm_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [WORD_W-1:0] req_eye_x,
   input  logic signed [WORD_W-1:0] req_eye_y,
   input  logic signed [WORD_W-1:0] req_eye_z,
   input  logic signed [WORD_W-1:0] req_target_x,
   input  logic signed [WORD_W-1:0] req_target_y,
   input  logic signed [WORD_W-1:0] req_target_z,
   input  logic signed [WORD_W-1:0] req_world_up_x,
   input  logic signed [WORD_W-1:0] req_world_up_y,
   input  logic signed [WORD_W-1:0] req_world_up_z,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [AXIS_W-1:0] rsp_right_x,
   output logic signed [AXIS_W-1:0] rsp_right_y,
   output logic signed [AXIS_W-1:0] rsp_right_z,
   output logic signed [AXIS_W-1:0] rsp_camup_x,
   output logic signed [AXIS_W-1:0] rsp_camup_y,
   output logic signed [AXIS_W-1:0] rsp_camup_z,
   output logic signed [AXIS_W-1:0] rsp_back_x,
   output logic signed [AXIS_W-1:0] rsp_back_y,
   output logic signed [AXIS_W-1:0] rsp_back_z,
   output logic signed [WORD_W-1:0] rsp_shift_x,
   output logic signed [WORD_W-1:0] rsp_shift_y,
   output logic signed [WORD_W-1:0] rsp_shift_z
);

   localparam int LU    = unit_lat(FRAC_BITS);
   localparam int AW    = FRAC_BITS + 2;
   localparam int TW    = 2 * FRAC_BITS + 4;
   localparam int CW    = TW + 1;
   localparam int DPW   = AW + WORD_W;
   localparam int DSW   = AW + WORD_W + 2;
   localparam int DV    = 2 * LU + 2;
   localparam int DB    = LU + 2;
   localparam int ONE_I = 1 << FRAC_BITS;

   logic en;
   logic [1:0] count_ff;

   assign en        = (count_ff != 2'd2);
   assign req_ready = en & ~reset;

   // input stage
   logic signed [WORD_W-1:0] eye0_ff  [3];
   logic signed [WORD_W:0]   diff0_ff [3];
   logic signed [WORD_W:0]   up0_ff   [3];
   logic                     v0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         eye0_ff[0]  <= req_eye_x;
         eye0_ff[1]  <= req_eye_y;
         eye0_ff[2]  <= req_eye_z;
         diff0_ff[0] <= (WORD_W+1)'(req_eye_x) - (WORD_W+1)'(req_target_x);
         diff0_ff[1] <= (WORD_W+1)'(req_eye_y) - (WORD_W+1)'(req_target_y);
         diff0_ff[2] <= (WORD_W+1)'(req_eye_z) - (WORD_W+1)'(req_target_z);
         up0_ff[0]   <= (WORD_W+1)'(req_world_up_x);
         up0_ff[1]   <= (WORD_W+1)'(req_world_up_y);
         up0_ff[2]   <= (WORD_W+1)'(req_world_up_z);
      end
   end

   // backward axis and unit world up
   logic signed [AW-1:0] back1 [3];
   logic signed [AW-1:0] up1   [3];

   lavm_unit #(.FRAC_BITS(FRAC_BITS), .IN_W(WORD_W+1)) u_back (
      .clock (clock),
      .en    (en),
      .in_x  (diff0_ff[0]),
      .in_y  (diff0_ff[1]),
      .in_z  (diff0_ff[2]),
      .out_x (back1[0]),
      .out_y (back1[1]),
      .out_z (back1[2])
   );

   lavm_unit #(.FRAC_BITS(FRAC_BITS), .IN_W(WORD_W+1)) u_up (
      .clock (clock),
      .en    (en),
      .in_x  (up0_ff[0]),
      .in_y  (up0_ff[1]),
      .in_z  (up0_ff[2]),
      .out_x (up1[0]),
      .out_y (up1[1]),
      .out_z (up1[2])
   );

   // up cross back: products, then differences
   logic signed [TW-1:0] pr1_ff  [6];
   logic signed [TW-1:0] crs1_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         pr1_ff[0] <= TW'(up1[1]) * TW'(back1[2]);
         pr1_ff[1] <= TW'(up1[2]) * TW'(back1[1]);
         pr1_ff[2] <= TW'(up1[2]) * TW'(back1[0]);
         pr1_ff[3] <= TW'(up1[0]) * TW'(back1[2]);
         pr1_ff[4] <= TW'(up1[0]) * TW'(back1[1]);
         pr1_ff[5] <= TW'(up1[1]) * TW'(back1[0]);
         for (int k = 0; k < 3; k++)
            crs1_ff[k] <= TW'(CW'(pr1_ff[2*k]) - CW'(pr1_ff[2*k+1]));
      end
   end

   logic signed [AW-1:0] right2 [3];

   lavm_unit #(.FRAC_BITS(FRAC_BITS), .IN_W(TW)) u_right (
      .clock (clock),
      .en    (en),
      .in_x  (crs1_ff[0]),
      .in_y  (crs1_ff[1]),
      .in_z  (crs1_ff[2]),
      .out_x (right2[0]),
      .out_y (right2[1]),
      .out_z (right2[2])
   );

   // delay lines that keep eye, backward axis and valid aligned with the normalizers
   logic signed [WORD_W-1:0] eyed_ff  [DV][3];
   logic signed [AW-1:0]     backd_ff [DB][3];
   logic                     vdl_ff   [DV];

   always_ff @(posedge clock) begin
      if (en) begin
         eyed_ff[0]  <= eye0_ff;
         backd_ff[0] <= back1;
         for (int i = 1; i < DV; i++) eyed_ff[i]  <= eyed_ff[i-1];
         for (int i = 1; i < DB; i++) backd_ff[i] <= backd_ff[i-1];
      end
   end

   // back cross right
   logic signed [TW-1:0]     pr2_ff [6];
   logic signed [AW-1:0]     rt_e1_ff [3];
   logic signed [AW-1:0]     bk_e1_ff [3];
   logic signed [WORD_W-1:0] eye_e1_ff [3];
   logic                     v_e1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pr2_ff[0] <= TW'(backd_ff[DB-1][1]) * TW'(right2[2]);
         pr2_ff[1] <= TW'(backd_ff[DB-1][2]) * TW'(right2[1]);
         pr2_ff[2] <= TW'(backd_ff[DB-1][2]) * TW'(right2[0]);
         pr2_ff[3] <= TW'(backd_ff[DB-1][0]) * TW'(right2[2]);
         pr2_ff[4] <= TW'(backd_ff[DB-1][0]) * TW'(right2[1]);
         pr2_ff[5] <= TW'(backd_ff[DB-1][1]) * TW'(right2[0]);
         rt_e1_ff  <= right2;
         bk_e1_ff  <= backd_ff[DB-1];
         eye_e1_ff <= eyed_ff[DV-1];
      end
   end

   // camera up: round half away from zero, clamp to one
   logic signed [AW-1:0]     cam_in    [3];
   logic signed [AW-1:0]     cam_e2_ff [3];
   logic signed [AW-1:0]     rt_e2_ff  [3];
   logic signed [AW-1:0]     bk_e2_ff  [3];
   logic signed [WORD_W-1:0] eye_e2_ff [3];
   logic                     v_e2_ff;

   always_comb begin
      logic signed [CW-1:0] cd;
      logic [CW-1:0]        cm, cr;
      for (int k = 0; k < 3; k++) begin
         cd = CW'(pr2_ff[2*k]) - CW'(pr2_ff[2*k+1]);
         cm = (cd < 0) ? CW'(-cd) : CW'(cd);
         cr = (cm + (CW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
         if (cr > (CW'(1) << FRAC_BITS)) cr = CW'(1) << FRAC_BITS;
         cam_in[k] = (cd < 0) ? -(AW'(cr)) : AW'(cr);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cam_e2_ff <= cam_in;
         rt_e2_ff  <= rt_e1_ff;
         bk_e2_ff  <= bk_e1_ff;
         eye_e2_ff <= eye_e1_ff;
      end
   end

   // translation: axis times eye, sums, round, negate, saturate
   logic signed [DPW-1:0]    dp_ff     [3][3];
   logic signed [AW-1:0]     ax_e3_ff  [3][3];
   logic                     v_e3_ff;
   logic signed [DSW-1:0]    ds_ff     [3];
   logic signed [AW-1:0]     ax_e4_ff  [3][3];
   logic                     v_e4_ff;
   logic signed [WORD_W-1:0] sh_in     [3];
   logic signed [WORD_W-1:0] sh_e5_ff  [3];
   logic signed [AW-1:0]     ax_e5_ff  [3][3];
   logic                     v_e5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dp_ff[0][i]    <= DPW'(rt_e2_ff[i])  * DPW'(eye_e2_ff[i]);
            dp_ff[1][i]    <= DPW'(cam_e2_ff[i]) * DPW'(eye_e2_ff[i]);
            dp_ff[2][i]    <= DPW'(bk_e2_ff[i])  * DPW'(eye_e2_ff[i]);
            ax_e3_ff[0][i] <= rt_e2_ff[i];
            ax_e3_ff[1][i] <= cam_e2_ff[i];
            ax_e3_ff[2][i] <= bk_e2_ff[i];
         end
         for (int j = 0; j < 3; j++)
            ds_ff[j] <= DSW'(dp_ff[j][0]) + DSW'(dp_ff[j][1]) + DSW'(dp_ff[j][2]);
         ax_e4_ff <= ax_e3_ff;
         sh_e5_ff <= sh_in;
         ax_e5_ff <= ax_e4_ff;
      end
   end

   always_comb begin
      logic [DSW-1:0] dm, dr, dn;
      for (int j = 0; j < 3; j++) begin
         dm = (ds_ff[j] < 0) ? DSW'(-ds_ff[j]) : DSW'(ds_ff[j]);
         dr = (dm + (DSW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
         dn = DSW'(0) - dr;
         if (ds_ff[j] < 0)
            sh_in[j] = (dr > DSW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : dr[WORD_W-1:0];
         else
            sh_in[j] = (dr > DSW'(32'h8000_0000)) ? 32'sh8000_0000 : dn[WORD_W-1:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff   <= 1'b0;
         v_e1_ff <= 1'b0;
         v_e2_ff <= 1'b0;
         v_e3_ff <= 1'b0;
         v_e4_ff <= 1'b0;
         v_e5_ff <= 1'b0;
         for (int i = 0; i < DV; i++) vdl_ff[i] <= 1'b0;
      end else if (en) begin
         v0_ff     <= req_valid;
         vdl_ff[0] <= v0_ff;
         for (int i = 1; i < DV; i++) vdl_ff[i] <= vdl_ff[i-1];
         v_e1_ff   <= vdl_ff[DV-1];
         v_e2_ff   <= v_e1_ff;
         v_e3_ff   <= v_e2_ff;
         v_e4_ff   <= v_e3_ff;
         v_e5_ff   <= v_e4_ff;
      end
   end

   // output queue, two beats deep
   rsp_type push_data;
   rsp_type fifo_ff [2];
   logic    wr_ptr_ff, rd_ptr_ff;
   logic    push, pop;

   assign push = en & v_e5_ff;
   assign pop  = rsp_valid & rsp_ready;

   always_comb begin
      push_data.right_x = AXIS_W'(ax_e5_ff[0][0]);
      push_data.right_y = AXIS_W'(ax_e5_ff[0][1]);
      push_data.right_z = AXIS_W'(ax_e5_ff[0][2]);
      push_data.camup_x = AXIS_W'(ax_e5_ff[1][0]);
      push_data.camup_y = AXIS_W'(ax_e5_ff[1][1]);
      push_data.camup_z = AXIS_W'(ax_e5_ff[1][2]);
      push_data.back_x  = AXIS_W'(ax_e5_ff[2][0]);
      push_data.back_y  = AXIS_W'(ax_e5_ff[2][1]);
      push_data.back_z  = AXIS_W'(ax_e5_ff[2][2]);
      push_data.shift_x = sh_e5_ff[0];
      push_data.shift_y = sh_e5_ff[1];
      push_data.shift_z = sh_e5_ff[2];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_right_x = fifo_ff[rd_ptr_ff].right_x;
   assign rsp_right_y = fifo_ff[rd_ptr_ff].right_y;
   assign rsp_right_z = fifo_ff[rd_ptr_ff].right_z;
   assign rsp_camup_x = fifo_ff[rd_ptr_ff].camup_x;
   assign rsp_camup_y = fifo_ff[rd_ptr_ff].camup_y;
   assign rsp_camup_z = fifo_ff[rd_ptr_ff].camup_z;
   assign rsp_back_x  = fifo_ff[rd_ptr_ff].back_x;
   assign rsp_back_y  = fifo_ff[rd_ptr_ff].back_y;
   assign rsp_back_z  = fifo_ff[rd_ptr_ff].back_z;
   assign rsp_shift_x = fifo_ff[rd_ptr_ff].shift_x;
   assign rsp_shift_y = fifo_ff[rd_ptr_ff].shift_y;
   assign rsp_shift_z = fifo_ff[rd_ptr_ff].shift_z;

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output queue overflow");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v_e5_ff) && $stable(v_e1_ff))
      else $error("pipeline moved while stalled");

   a_cam_range: assert property (@(posedge clock) disable iff (reset)
      v_e2_ff |-> (cam_e2_ff[0] <= ONE_I) && (cam_e2_ff[0] >= -ONE_I)
               && (cam_e2_ff[1] <= ONE_I) && (cam_e2_ff[1] >= -ONE_I)
               && (cam_e2_ff[2] <= ONE_I) && (cam_e2_ff[2] >= -ONE_I))
      else $error("camera up axis out of range");
`endif

endmodule
